// ----- rtl/core/swks_pkg.sv -----
// Shared constants, types and helpers of the sliding window key search unit.
`default_nettype none

package swks_pkg;

   localparam int KEY_ENTRIES = 16;
   localparam int SLOT_BITS   = 4;
   localparam int COUNT_BITS  = 5;
   localparam int BYTE_BITS   = 8;
   localparam int WORD_BITS   = 32;
   localparam int WIDTHS      = 3;
   localparam int ADDR_BITS   = 3;
   localparam int CSR_BITS    = 32;

   localparam logic [WORD_BITS-1:0] POS_MAX = '1;

   localparam logic [1:0] WIDTH_ONE  = 2'd0;
   localparam logic [1:0] WIDTH_TWO  = 2'd1;
   localparam logic [1:0] WIDTH_FOUR = 2'd2;

   localparam logic ACTION_LOAD = 1'b0;
   localparam logic ACTION_DATA = 1'b1;

   localparam logic REG_KEY_COUNT = 1'b0;

   // Window words of one byte, both byte orders, for each window width.
   typedef struct packed {
      logic [WIDTHS-1:0][WORD_BITS-1:0] le;
      logic [WIDTHS-1:0][WORD_BITS-1:0] be;
      logic [WIDTHS-1:0]                valid;
   } swks_window_type;

   // Grant chain that runs from key cell 0 upward.
   typedef struct packed {
      logic                 found;
      logic                 found_two;
      logic [SLOT_BITS-1:0] slot;
      logic [WORD_BITS-1:0] key;
   } swks_chain_type;

   function automatic logic pick_width(input logic [WIDTHS-1:0] bits,
                                       input logic [1:0] code);
      logic result;
      case (code)
         WIDTH_ONE:  result = bits[0];
         WIDTH_TWO:  result = bits[1];
         WIDTH_FOUR: result = bits[2];
         default:    result = 1'b0;
      endcase
      return result;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/swks_key_cell.sv -----
// One key cell: holds a key, compares it with the windows and takes part in the grant chain.
`default_nettype none

module swks_key_cell (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire  [swks_pkg::SLOT_BITS-1:0]       cell_index,
   input  wire                                  in_use,
   input  wire                                  key_load,
   input  wire  [swks_pkg::WORD_BITS-1:0]       key_word,
   input  wire                                  compare,
   input  swks_pkg::swks_window_type            window,
   input  wire  [1:0]                           sel_width,
   input  wire                                  take,
   input  wire  [swks_pkg::WIDTHS-1:0]          any_in,
   output logic [swks_pkg::WIDTHS-1:0]          any_out,
   input  swks_pkg::swks_chain_type             chain_in,
   output swks_pkg::swks_chain_type             chain_out
);
   import swks_pkg::*;

   logic [WORD_BITS-1:0] key_ff;
   logic [WIDTHS-1:0]    hits_ff;
   logic [WIDTHS-1:0]    hits_in;
   logic [WIDTHS-1:0]    new_hits;
   logic [WIDTHS-1:0]    clear_mask;
   logic                 my_hit;
   logic                 grant;

   always_comb begin
      for (int w = 0; w < WIDTHS; w++) begin
         new_hits[w] = window.valid[w] && in_use &&
                       ((window.le[w] == key_ff) || (window.be[w] == key_ff));
      end
   end

   assign my_hit = pick_width(hits_ff, sel_width);
   assign grant  = my_hit && !chain_in.found;

   always_comb begin
      clear_mask = '0;
      case (sel_width)
         WIDTH_ONE:  clear_mask[0] = 1'b1;
         WIDTH_TWO:  clear_mask[1] = 1'b1;
         WIDTH_FOUR: clear_mask[2] = 1'b1;
         default:    clear_mask = '0;
      endcase
   end

   always_comb begin
      hits_in = hits_ff;
      if (compare) begin
         hits_in = new_hits;
      end else if (take && grant) begin
         hits_in = hits_ff & ~clear_mask;
      end
   end

   always_comb begin
      any_out             = any_in | hits_ff;
      chain_out.found     = chain_in.found | my_hit;
      chain_out.found_two = chain_in.found_two | (chain_in.found & my_hit);
      chain_out.slot      = chain_in.slot | (grant ? cell_index : '0);
      chain_out.key       = chain_in.key | (grant ? key_ff : '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hits_ff <= '0;
      end else begin
         hits_ff <= hits_in;
      end
   end

   always_ff @(posedge clock) begin
      if (key_load) begin
         key_ff <= key_word;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/sliding_window_key_search_unit.sv -----
// Top level of the sliding window key search unit: byte window, key cell row and result register.
`default_nettype none

// The unit holds a row of key cells, loaded by requests with action 0, and scans a file one
// byte per request with action 1. Every key cell compares its key with the 1-, 2- and 4-byte
// windows ending at the new byte, in both byte orders, in the cycle the request is accepted.
// A byte without hits does not stall the next request. Hits leave one per cycle, unless rsp_stall
// holds the result register, through the cell row's grant chain into that register, width by
// width and by ascending slot. Requests stall while hits of the previous byte wait; the next
// request is taken in the cycle its last result is loaded. key_count is read through csr_paddr
// 0; the user writes configuration only while the unit is idle, which the unit does not enforce.
module sliding_window_key_search_unit (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_valid,
   output logic                                  req_stall,
   input  wire                                   req_action,
   input  wire  [swks_pkg::SLOT_BITS-1:0]        req_key_slot,
   input  wire  [swks_pkg::WORD_BITS-1:0]        req_key_word,
   input  wire  [swks_pkg::BYTE_BITS-1:0]        req_data_byte,
   input  wire                                   req_last_of_file,
   output logic                                  rsp_valid,
   input  wire                                   rsp_stall,
   output logic [swks_pkg::WORD_BITS-1:0]        rsp_match_offset,
   output logic [1:0]                            rsp_width_code,
   output logic [swks_pkg::SLOT_BITS-1:0]        rsp_hit_slot,
   output logic [swks_pkg::WORD_BITS-1:0]        rsp_hit_key,
   output logic                                  rsp_last,
   input  wire                                   csr_psel,
   input  wire                                   csr_penable,
   input  wire                                   csr_pwrite,
   input  wire  [swks_pkg::ADDR_BITS-1:0]        csr_paddr,
   input  wire  [swks_pkg::CSR_BITS-1:0]         csr_pwdata,
   output logic [swks_pkg::CSR_BITS-1:0]         csr_prdata,
   output logic                                  csr_pready
);
   import swks_pkg::*;

   logic [COUNT_BITS-1:0]            key_count_ff;
   logic [3*BYTE_BITS-1:0]           recent_ff;
   logic [1:0]                       seen_ff;
   logic [WORD_BITS-1:0]             pos_ff;
   logic [WIDTHS-1:0][WORD_BITS-1:0] offset_ff;
   logic [WIDTHS-1:0][WORD_BITS-1:0] offset_in;

   logic                             rsp_valid_ff;
   logic [WORD_BITS-1:0]             rsp_offset_ff;
   logic [1:0]                       rsp_width_ff;
   logic [SLOT_BITS-1:0]             rsp_slot_ff;
   logic [WORD_BITS-1:0]             rsp_key_ff;
   logic                             rsp_last_ff;

   logic                             accept;
   logic                             data_accept;
   logic                             busy;
   logic                             take;
   logic                             last_hit;
   logic                             higher_hits;
   logic                             saturated;
   logic [1:0]                       sel_width;
   logic [COUNT_BITS-1:0]            used;
   logic [KEY_ENTRIES-1:0]           in_use;
   logic [BYTE_BITS-1:0]             cur;
   logic [BYTE_BITS-1:0]             b0;
   logic [BYTE_BITS-1:0]             b1;
   logic [BYTE_BITS-1:0]             b2;
   logic                             csr_write;
   swks_window_type                  window;

   logic [KEY_ENTRIES:0][WIDTHS-1:0] any_chain;
   swks_chain_type                   chain [KEY_ENTRIES+1];

   // Configuration port.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && (csr_paddr[2] == REG_KEY_COUNT);
   assign csr_prdata = (csr_paddr[2] == REG_KEY_COUNT) ?
                       {{(CSR_BITS-COUNT_BITS){1'b0}}, key_count_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_count_ff <= '0;
      end else if (csr_write) begin
         key_count_ff <= csr_pwdata[COUNT_BITS-1:0];
      end
   end

   assign used = (key_count_ff > COUNT_BITS'(KEY_ENTRIES)) ? COUNT_BITS'(KEY_ENTRIES)
                                                           : key_count_ff;

   // Result selection: lowest width with a pending hit, lowest slot within it.
   assign busy = |any_chain[KEY_ENTRIES];

   always_comb begin
      if (any_chain[KEY_ENTRIES][0]) begin
         sel_width = WIDTH_ONE;
      end else if (any_chain[KEY_ENTRIES][1]) begin
         sel_width = WIDTH_TWO;
      end else begin
         sel_width = WIDTH_FOUR;
      end
   end

   always_comb begin
      case (sel_width)
         WIDTH_ONE:  higher_hits = any_chain[KEY_ENTRIES][1] | any_chain[KEY_ENTRIES][2];
         WIDTH_TWO:  higher_hits = any_chain[KEY_ENTRIES][2];
         default:    higher_hits = 1'b0;
      endcase
   end

   assign last_hit = !chain[KEY_ENTRIES].found_two && !higher_hits;
   assign take     = busy && (!rsp_valid_ff || !rsp_stall);

   // The last pending hit leaves in this cycle, so a new request may enter alongside it.
   assign req_stall   = busy && !(take && last_hit);
   assign accept      = req_valid && !req_stall;
   assign data_accept = accept && (req_action == ACTION_DATA);

   // Window words for the incoming byte.
   assign cur       = req_data_byte;
   assign b0        = recent_ff[BYTE_BITS-1:0];
   assign b1        = recent_ff[2*BYTE_BITS-1:BYTE_BITS];
   assign b2        = recent_ff[3*BYTE_BITS-1:2*BYTE_BITS];
   assign saturated = (pos_ff == POS_MAX);

   always_comb begin
      window.le[0]    = {{(WORD_BITS-BYTE_BITS){1'b0}}, cur};
      window.be[0]    = {{(WORD_BITS-BYTE_BITS){1'b0}}, cur};
      window.le[1]    = {{(WORD_BITS-2*BYTE_BITS){1'b0}}, cur, b0};
      window.be[1]    = {{(WORD_BITS-2*BYTE_BITS){1'b0}}, b0, cur};
      window.le[2]    = {cur, b0, b1, b2};
      window.be[2]    = {b2, b1, b0, cur};
      window.valid[0] = 1'b1;
      window.valid[1] = (seen_ff != 2'd0);
      window.valid[2] = (seen_ff == 2'd3);
      offset_in[0]    = pos_ff;
      offset_in[1]    = saturated ? POS_MAX : pos_ff - WORD_BITS'(1);
      offset_in[2]    = saturated ? POS_MAX : pos_ff - WORD_BITS'(3);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         recent_ff <= '0;
         seen_ff   <= '0;
         pos_ff    <= '0;
      end else if (data_accept) begin
         if (req_last_of_file) begin
            recent_ff <= '0;
            seen_ff   <= '0;
            pos_ff    <= '0;
         end else begin
            recent_ff <= {recent_ff[2*BYTE_BITS-1:0], cur};
            if (seen_ff != 2'd3) begin
               seen_ff <= seen_ff + 2'd1;
            end
            if (!saturated) begin
               pos_ff <= pos_ff + WORD_BITS'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (data_accept) begin
         offset_ff <= offset_in;
      end
   end

   // Row of key cells.
   assign any_chain[0] = '0;
   assign chain[0]     = '0;

   for (genvar i = 0; i < KEY_ENTRIES; i++) begin : g_cell
      assign in_use[i] = (COUNT_BITS'(i) < used);

      swks_key_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (SLOT_BITS'(i)),
         .in_use     (in_use[i]),
         .key_load   (accept && (req_action == ACTION_LOAD) &&
                      (req_key_slot == SLOT_BITS'(i)) &&
                      ({1'b0, req_key_slot} < COUNT_BITS'(KEY_ENTRIES))),
         .key_word   (req_key_word),
         .compare    (data_accept),
         .window     (window),
         .sel_width  (sel_width),
         .take       (take),
         .any_in     (any_chain[i]),
         .any_out    (any_chain[i+1]),
         .chain_in   (chain[i]),
         .chain_out  (chain[i+1])
      );
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (take) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         case (sel_width)
            WIDTH_ONE:  rsp_offset_ff <= offset_ff[0];
            WIDTH_TWO:  rsp_offset_ff <= offset_ff[1];
            default:    rsp_offset_ff <= offset_ff[2];
         endcase
         rsp_width_ff <= sel_width;
         rsp_slot_ff  <= chain[KEY_ENTRIES].slot;
         rsp_key_ff   <= chain[KEY_ENTRIES].key;
         rsp_last_ff  <= last_hit;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_match_offset = rsp_offset_ff;
   assign rsp_width_code   = rsp_width_ff;
   assign rsp_hit_slot     = rsp_slot_ff;
   assign rsp_hit_key      = rsp_key_ff;
   assign rsp_last         = rsp_last_ff;

endmodule

`default_nettype wire

// ----- test/tb_sliding_window_key_search_unit.sv -----
// Testbench of the sliding window key search unit: key loads, byte streams and match checking.
`timescale 1ns / 1ps

module tb_sliding_window_key_search_unit;
   import swks_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int QUIET_CYCLES = 8;
   localparam int PHASE_BYTES  = 42;

   typedef struct packed {
      logic [WORD_BITS-1:0] offset;
      logic [1:0]           width;
      logic [SLOT_BITS-1:0] slot;
      logic [WORD_BITS-1:0] key;
      logic                 last;
   } match_rec_type;

   // Tracks the key table and the byte window, and holds the matches still owed by the unit.
   class match_board;
      logic [WORD_BITS-1:0]  keys [KEY_ENTRIES];
      logic [COUNT_BITS-1:0] key_count;
      logic [23:0]           recent;
      logic [1:0]            seen;
      logic [WORD_BITS-1:0]  position;
      match_rec_type         due [$];
      int                    errors;

      function new();
         key_count = '0;
         recent    = '0;
         seen      = '0;
         position  = '0;
         errors    = 0;
         foreach (keys[i]) keys[i] = '0;
      endfunction

      function int pending();
         return due.size();
      endfunction

      function void add_hits(input logic [WORD_BITS-1:0] le, input logic [WORD_BITS-1:0] be,
                             input logic [WORD_BITS-1:0] start, input logic [1:0] code,
                             input int used);
         match_rec_type r;
         for (int s = 0; s < used; s++) begin
            if (le == keys[s] || be == keys[s]) begin
               r.offset = start;
               r.width  = code;
               r.slot   = SLOT_BITS'(s);
               r.key    = keys[s];
               r.last   = 1'b0;
               due      = {due, r};
            end
         end
      endfunction

      function void note_request(input logic act, input logic [SLOT_BITS-1:0] slot,
                                 input logic [WORD_BITS-1:0] word,
                                 input logic [BYTE_BITS-1:0] cur, input logic eof);
         int                   used;
         int                   start_size;
         logic                 sat;
         logic [BYTE_BITS-1:0] b0, b1, b2;
         if (act == ACTION_LOAD) begin
            keys[slot] = word;
            return;
         end
         used = (key_count > KEY_ENTRIES) ? KEY_ENTRIES : int'(key_count);
         sat = (position == POS_MAX);
         {b2, b1, b0} = recent;
         start_size = due.size();
         add_hits({24'b0, cur}, {24'b0, cur}, position, WIDTH_ONE, used);
         if (seen >= 2'd1)
            add_hits({16'b0, cur, b0}, {16'b0, b0, cur}, sat ? POS_MAX : position - 32'd1,
                     WIDTH_TWO, used);
         if (seen == 2'd3)
            add_hits({cur, b0, b1, b2}, {b2, b1, b0, cur}, sat ? POS_MAX : position - 32'd3,
                     WIDTH_FOUR, used);
         if (due.size() > start_size)
            due[due.size() - 1].last = 1'b1;
         if (eof) begin
            recent   = '0;
            seen     = '0;
            position = '0;
         end else begin
            recent = {recent[15:0], cur};
            if (seen != 2'd3) seen = seen + 2'd1;
            if (!sat) position = position + 32'd1;
         end
      endfunction

      function void check_result(input match_rec_type got);
         match_rec_type want;
         if (due.size() == 0) begin
            $error("unexpected match: offset %0h slot %0d", got.offset, got.slot);
            errors++;
            return;
         end
         want = due.pop_front();
         if (got.offset !== want.offset) begin
            $error("match_offset: expected %0h, actual %0h", want.offset, got.offset);
            errors++;
         end
         if (got.width !== want.width) begin
            $error("width_code: expected %0d, actual %0d", want.width, got.width);
            errors++;
         end
         if (got.slot !== want.slot) begin
            $error("hit_slot: expected %0d, actual %0d", want.slot, got.slot);
            errors++;
         end
         if (got.key !== want.key) begin
            $error("hit_key: expected %0h, actual %0h", want.key, got.key);
            errors++;
         end
         if (got.last !== want.last) begin
            $error("last: expected %0b, actual %0b", want.last, got.last);
            errors++;
         end
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic                 req_action;
   logic [SLOT_BITS-1:0] req_key_slot;
   logic [WORD_BITS-1:0] req_key_word;
   logic [BYTE_BITS-1:0] req_data_byte;
   logic                 req_last_of_file;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [WORD_BITS-1:0] rsp_match_offset;
   logic [1:0]           rsp_width_code;
   logic [SLOT_BITS-1:0] rsp_hit_slot;
   logic [WORD_BITS-1:0] rsp_hit_key;
   logic                 rsp_last;
   logic                 csr_psel;
   logic                 csr_penable;
   logic                 csr_pwrite;
   logic [ADDR_BITS-1:0] csr_paddr;
   logic [CSR_BITS-1:0]  csr_pwdata;
   logic [CSR_BITS-1:0]  csr_prdata;
   logic                 csr_pready;

   match_board book;
   bit         steady;
   int         cycle_count;

   sliding_window_key_search_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_key_slot     (req_key_slot),
      .req_key_word     (req_key_word),
      .req_data_byte    (req_data_byte),
      .req_last_of_file (req_last_of_file),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_match_offset (rsp_match_offset),
      .rsp_width_code   (rsp_width_code),
      .rsp_hit_slot     (rsp_hit_slot),
      .rsp_hit_key      (rsp_hit_key),
      .rsp_last         (rsp_last),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL sliding_window_key_search_unit");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_stall <= !steady && ($urandom_range(99) < 12);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         book.check_result({rsp_match_offset, rsp_width_code, rsp_hit_slot, rsp_hit_key,
                            rsp_last});
   end

   // Entered and left at a falling edge; the request is noted at the edge that accepts it.
   task automatic send_request(input logic act, input logic [SLOT_BITS-1:0] slot,
                               input logic [WORD_BITS-1:0] word,
                               input logic [BYTE_BITS-1:0] data, input logic eof);
      while (!steady && $urandom_range(99) < 12) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_action       <= act;
      req_key_slot     <= slot;
      req_key_word     <= word;
      req_data_byte    <= data;
      req_last_of_file <= eof;
      do @(posedge clock); while (req_stall);
      book.note_request(act, slot, word, data, eof);
      @(negedge clock);
   endtask

   task automatic send_load(input logic [SLOT_BITS-1:0] slot, input logic [WORD_BITS-1:0] word);
      send_request(ACTION_LOAD, slot, word, BYTE_BITS'($urandom), 1'($urandom));
   endtask

   task automatic send_data(input logic [BYTE_BITS-1:0] data, input logic eof);
      send_request(ACTION_DATA, SLOT_BITS'($urandom), $urandom, data, eof);
   endtask

   // Drops req_valid and waits until the unit owes no match; QUIET_CYCLES quiet clocks then follow.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (book.pending() != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_key_count(input logic [COUNT_BITS-1:0] count);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {REG_KEY_COUNT, 2'b00};
      csr_pwdata  <= CSR_BITS'(count);
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      book.key_count = count;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Keys are mostly built from four bytes that also dominate the stream, so hits are common.
   function automatic logic [WORD_BITS-1:0] make_key(input logic [3:0][BYTE_BITS-1:0] alpha);
      logic [WORD_BITS-1:0] k;
      case ($urandom_range(4))
         0: k = {24'b0, alpha[$urandom_range(3)]};
         1: k = {16'b0, alpha[$urandom_range(3)], alpha[$urandom_range(3)]};
         2: k = {alpha[$urandom_range(3)], alpha[$urandom_range(3)],
                 alpha[$urandom_range(3)], alpha[$urandom_range(3)]};
         default: k = $urandom;
      endcase
      return k;
   endfunction

   task automatic run_phase(input logic [COUNT_BITS-1:0] count, input bit calm);
      logic [3:0][BYTE_BITS-1:0] alpha;
      int                        sent;
      wait_idle();
      write_key_count(count);
      steady = calm;
      alpha = {$urandom};
      for (int s = 0; s < KEY_ENTRIES; s++) send_load(SLOT_BITS'(s), make_key(alpha));
      sent = 0;
      while (sent < PHASE_BYTES) begin
         if ($urandom_range(99) < 6) begin
            send_load(SLOT_BITS'($urandom), make_key(alpha));
         end else begin
            send_data(($urandom_range(99) < 85) ? alpha[$urandom_range(3)] : BYTE_BITS'($urandom),
                      $urandom_range(9) == 0);
            sent++;
         end
      end
   endtask

   initial begin
      logic [COUNT_BITS-1:0] count;
      book             = new();
      cycle_count      = 0;
      steady           = 1'b0;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_action       = ACTION_LOAD;
      req_key_slot     = '0;
      req_key_word     = '0;
      req_data_byte    = '0;
      req_last_of_file = 1'b0;
      rsp_stall        = 1'b0;
      csr_psel         = 1'b0;
      csr_penable      = 1'b0;
      csr_pwrite       = 1'b0;
      csr_paddr        = '0;
      csr_pwdata       = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Every slot holds zero before any key is in use.
      for (int s = 0; s < KEY_ENTRIES; s++) send_load(SLOT_BITS'(s), '0);
      wait_idle();
      write_key_count(COUNT_BITS'(KEY_ENTRIES));
      // A file of four zero bytes: the last byte hits every slot at every width.
      repeat (3) send_data(8'h00, 1'b0);
      send_data(8'h00, 1'b1);
      send_load(SLOT_BITS'(0), 32'h0000_00FF);
      send_load(SLOT_BITS'(KEY_ENTRIES - 1), 32'hFFFF_FFFF);
      repeat (3) send_data(8'hFF, 1'b0);
      send_data(8'hFF, 1'b1);
      // A two-byte file whose two-byte window matches only in its little-endian reading.
      send_data(8'hFF, 1'b0);
      send_data(8'h00, 1'b1);

      for (int p = 0; p < 7; p++) begin
         case (p)
            0: count = COUNT_BITS'(KEY_ENTRIES);
            1: count = '1;
            2: count = '0;
            3: count = COUNT_BITS'(1);
            4: count = COUNT_BITS'(KEY_ENTRIES + 1);
            5: count = COUNT_BITS'($urandom_range(31));
            default: count = COUNT_BITS'(KEY_ENTRIES);
         endcase
         run_phase(count, p == 3);
      end

      steady = 1'b0;
      wait_idle();
      if (book.errors == 0)
         $display("PASS sliding_window_key_search_unit");
      else
         $display("FAIL sliding_window_key_search_unit");
      $finish;
   end

endmodule
